// ===== rtl/sre_pkg.sv =====
// shared types and constants for the static range encoder
package sre_pkg;
	localparam int CntW = 25;
	localparam int AccW = 33;
	localparam logic [AccW-1:0] FullWidth = 33'h0FFFFFFFF;
	localparam logic [AccW-1:0] RenormLimit = 33'h001000000;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_BYTE      = 2'd0,
		ST_ZERO_SYM  = 2'd1,
		ST_BAD_TOTAL = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;
endpackage

// ===== rtl/sre_ram.sv =====
// generic single-port ram with registered read
module sre_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/static_range_encoder_core.sv =====
// static-model byte range encoder top level
// An item is taken while in_stall is low and the core is idle. A load of a valid
// symbol writes its count when taken and the core stays idle. The first encode
// or flush after reset or a load first runs a prefix sum sweep, a read state
// and a write state per table entry. An encode then reads the table, runs the
// checks, a restoring divider (one quotient bit per cycle) and one multiply
// step each for the low update and the new width, all on one shared
// multiplier. Each emitted byte then passes a renorm state and an output state
// that holds while the consumer stalls, and a last renorm state ends the item.
// A flush takes a read state, a check state, and a flush and an output state
// per byte. After reset a clearing pass writes zero to every count entry, one
// per cycle, during which no item is taken.
module static_range_encoder_core
	import sre_pkg::*;
#(
	parameter int ALPHABET_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  symbol,
	input  logic [24:0] count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic        carry_lost,
	output logic        last
);
	localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int IW = AW + 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SUM_RD, S_SUM_WR, S_CHECK, S_RD, S_DIV,
		S_MUL_LOW, S_MUL_WID, S_RENORM, S_FLUSH, S_OUT
	} state_t;

	state_t           state_q;
	logic [IW-1:0]    idx_q;
	logic [1:0]       kind_q;
	logic [7:0]       sym_q;
	logic             ready_q;
	logic [AccW-1:0]  total_q, low_q, width_q, acc_q;
	logic [AccW-1:0]  rem_q, quo_q;
	logic [5:0]       bit_q;
	logic [2:0]       n_q;
	logic             after_q;   // 1: return to renorm or flush after out beat
	logic [7:0]       ob_q;
	logic [1:0]       st_q;
	logic             cl_q, last_q, ov_q;

	logic             cnt_we, cum_we;
	logic [AW-1:0]    cnt_addr;
	logic [CntW-1:0]  cnt_wdata, cnt_rdata;
	logic [AccW-1:0]  cum_rdata;

	sre_ram #(.Width(CntW), .Depth(ALPHABET_SIZE)) u_cnt (
		.clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
	);
	sre_ram #(.Width(AccW), .Depth(ALPHABET_SIZE)) u_cum (
		.clk(clk), .we(cum_we), .addr(cnt_addr), .wdata(acc_q), .rdata(cum_rdata)
	);

	logic sym_ok;
	assign sym_ok = ({1'b0, symbol} < 9'(ALPHABET_SIZE));
	logic take;
	assign take = (state_q == S_IDLE) && in_valid;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cnt_we = 1'b0;
		cum_we = 1'b0;
		cnt_wdata = count;
		cnt_addr = idx_q[AW-1:0];
		if (state_q == S_CLEAR) begin
			cnt_we = 1'b1;
			cnt_wdata = '0;
		end else if (state_q == S_SUM_WR) begin
			cum_we = 1'b1;
		end else if (state_q == S_IDLE) begin
			cnt_addr = symbol[AW-1:0];
			cnt_we = in_valid && (kind == KIND_LOAD) && sym_ok;
		end else if (state_q == S_RD || state_q == S_CHECK || state_q == S_DIV
			|| state_q == S_MUL_LOW || state_q == S_MUL_WID) begin
			cnt_addr = sym_q[AW-1:0];
		end
	end

	logic [AccW:0]  rem_sh;
	logic [AccW:0]  rem_sub;
	assign rem_sh  = {rem_q, width_q[6'(AccW-1) - bit_q]};
	assign rem_sub = rem_sh - {1'b0, total_q};

	// one multiplier, operand picked by the multiply state
	logic [AccW-1:0]   mul_b;
	logic [2*AccW-1:0] prod;
	assign mul_b = (state_q == S_MUL_LOW) ? cum_rdata : {8'd0, cnt_rdata};
	assign prod = {{AccW{1'b0}}, quo_q} * {{AccW{1'b0}}, mul_b};

	logic bad_total;
	assign bad_total = (total_q == '0) || (total_q > RenormLimit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			ready_q <= 1'b0;
			total_q <= '0;
			low_q <= '0;
			width_q <= FullWidth;
			ov_q <= 1'b0;
			kind_q <= '0;
			sym_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= '0;
			n_q <= '0;
			after_q <= 1'b0;
			ob_q <= '0;
			st_q <= '0;
			cl_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(ALPHABET_SIZE - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (take) begin
						kind_q <= kind;
						sym_q <= symbol;
						if (kind == KIND_LOAD) begin
							if (sym_ok) ready_q <= 1'b0;
						end else if (kind == KIND_ENCODE || kind == KIND_FLUSH) begin
							idx_q <= '0;
							acc_q <= '0;
							state_q <= ready_q ? S_RD : S_SUM_RD;
						end
					end
				end
				S_SUM_RD: state_q <= S_SUM_WR;
				S_SUM_WR: begin
					acc_q <= acc_q + {8'd0, cnt_rdata};
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(ALPHABET_SIZE - 1)) begin
						total_q <= acc_q + {8'd0, cnt_rdata};
						ready_q <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_SUM_RD;
					end
				end
				S_RD: state_q <= S_CHECK;
				S_CHECK: begin
					ob_q <= '0;
					cl_q <= 1'b0;
					last_q <= 1'b0;
					after_q <= 1'b0;
					n_q <= '0;
					if (kind_q == KIND_FLUSH) begin
						if (total_q == '0) begin
							st_q <= ST_EMPTY;
							last_q <= 1'b1;
							low_q <= '0;
							width_q <= FullWidth;
							ov_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							state_q <= S_FLUSH;
						end
					end else if (bad_total) begin
						st_q <= ST_BAD_TOTAL;
						ov_q <= 1'b1;
						state_q <= S_OUT;
					end else if (({1'b0, sym_q} >= 9'(ALPHABET_SIZE)) || cnt_rdata == '0) begin
						st_q <= ST_ZERO_SYM;
						ov_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (!rem_sub[AccW]) begin
						rem_q <= rem_sub[AccW-1:0];
						quo_q <= {quo_q[AccW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[AccW-1:0];
						quo_q <= {quo_q[AccW-2:0], 1'b0};
					end
					bit_q <= bit_q + 1'b1;
					if (bit_q == 6'(AccW-1)) state_q <= S_MUL_LOW;
				end
				S_MUL_LOW: begin
					low_q <= low_q + prod[AccW-1:0];
					state_q <= S_MUL_WID;
				end
				S_MUL_WID: begin
					width_q <= prod[AccW-1:0];
					state_q <= S_RENORM;
				end
				S_RENORM: begin
					if (width_q <= RenormLimit && n_q != 3'd4) begin
						ob_q <= low_q[31:24];
						cl_q <= low_q[32];
						st_q <= ST_BYTE;
						low_q <= {1'b0, low_q[23:0], 8'd0};
						width_q <= {width_q[24:0], 8'd0};
						n_q <= n_q + 1'b1;
						after_q <= 1'b1;
						ov_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					ob_q <= low_q[31:24];
					cl_q <= low_q[32];
					st_q <= ST_BYTE;
					last_q <= (n_q == 3'd3);
					n_q <= n_q + 1'b1;
					after_q <= 1'b1;
					ov_q <= 1'b1;
					if (n_q == 3'd3) begin
						low_q <= '0;
						width_q <= FullWidth;
						after_q <= 1'b0;
					end else begin
						low_q <= {1'b0, low_q[23:0], 8'd0};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						ov_q <= 1'b0;
						if (!after_q) state_q <= S_IDLE;
						else if (kind_q == KIND_FLUSH) state_q <= S_FLUSH;
						else state_q <= S_RENORM;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign out_byte   = ob_q;
	assign status     = st_q;
	assign carry_lost = cl_q;
	assign last       = last_q;

	a_valid_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result beat outside output state");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> kind_q == KIND_FLUSH) else $error("last outside flush");
	a_renorm_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 3'd4) else $error("too many bytes");
endmodule
